// File: src/pdad_pkg.sv
package pdad_pkg;

  localparam int DateW    = 27;
  localparam int CountInW = 16;
  localparam int RemW     = 14;

  localparam int DivYear  = 10000;
  localparam int DivMonth = 100;
  localparam int SpanDays = 1461;
  localparam int YearBase = 2000;
  localparam int YearLast = 2099;
  localparam int DayMax   = 31;
  localparam int MonthMax = 12;

  // floor(x / 625) for x < 2^23, i.e. date / 10000 after dropping four bits
  localparam logic [23:0] RecipYear   = 24'd13743896;
  localparam int          RecipYearSh = 33;
  // floor(x / 25) for x < 2^12, i.e. (date mod 10000) / 100 after dropping two bits
  localparam logic [12:0] RecipMonth   = 13'd5243;
  localparam int          RecipMonthSh = 17;
  // floor(k / 25) for k < 2^22
  localparam logic [22:0] Recip25   = 23'd5368710;
  localparam int          Recip25Sh = 27;

  localparam int SpanQW       = 22;  // four-year spans in the widest count
  localparam int KqW          = 18;
  localparam int SpansPerCent = 25;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIV_Y,
    OP_SPLIT,
    OP_DIV_M,
    OP_CHECK,
    OP_SKIP_SET,
    OP_SKIP_MOD,
    OP_SKIP_END,
    OP_WALK,
    OP_PACK_HI,
    OP_PACK_LO,
    OP_REJECT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_BAD,
    C_SHORT,
    C_OVER,
    C_OUT_BUSY
  } cond_t;

  // jump to jmp when cond holds, else go to nxt
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   jmp;
    pc_t   nxt;
  } uword_t;

  typedef struct packed {
    logic bad;         // split date out of range
    logic short_span;  // no four-year skip needed
    logic over;        // day does not fit current month
  } dp_stat_t;

  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_DIV_Y    = 4'd1;
  localparam pc_t PC_SPLIT    = 4'd2;
  localparam pc_t PC_DIV_M    = 4'd3;
  localparam pc_t PC_CHECK    = 4'd4;
  localparam pc_t PC_SKIP_SET = 4'd5;
  localparam pc_t PC_SKIP_MOD = 4'd6;
  localparam pc_t PC_SKIP_END = 4'd7;
  localparam pc_t PC_WALK     = 4'd8;
  localparam pc_t PC_PACK_HI  = 4'd9;
  localparam pc_t PC_PACK_LO  = 4'd10;
  localparam pc_t PC_REJECT   = 4'd11;
  localparam pc_t PC_LAST     = PC_REJECT;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = '{OP_IDLE,     C_NO_IN,    PC_IDLE,     PC_DIV_Y};
      PC_DIV_Y:    w = '{OP_DIV_Y,    C_NEVER,    PC_IDLE,     PC_SPLIT};
      PC_SPLIT:    w = '{OP_SPLIT,    C_NEVER,    PC_IDLE,     PC_DIV_M};
      PC_DIV_M:    w = '{OP_DIV_M,    C_NEVER,    PC_IDLE,     PC_CHECK};
      PC_CHECK:    w = '{OP_CHECK,    C_BAD,      PC_REJECT,   PC_SKIP_SET};
      PC_SKIP_SET: w = '{OP_SKIP_SET, C_SHORT,    PC_WALK,     PC_SKIP_MOD};
      PC_SKIP_MOD: w = '{OP_SKIP_MOD, C_NEVER,    PC_IDLE,     PC_SKIP_END};
      PC_SKIP_END: w = '{OP_SKIP_END, C_NEVER,    PC_IDLE,     PC_WALK};
      PC_WALK:     w = '{OP_WALK,     C_OVER,     PC_WALK,     PC_PACK_HI};
      PC_PACK_HI:  w = '{OP_PACK_HI,  C_NEVER,    PC_IDLE,     PC_PACK_LO};
      PC_PACK_LO:  w = '{OP_PACK_LO,  C_OUT_BUSY, PC_PACK_LO,  PC_IDLE};
      PC_REJECT:   w = '{OP_REJECT,   C_OUT_BUSY, PC_REJECT,   PC_IDLE};
      default:     w = '{OP_NOP,      C_NEVER,    PC_IDLE,     PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] mm, logic leap);
    logic [4:0] len;
    unique case (mm)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/pdad_dp.sv
module pdad_dp #(
  parameter int DAYS_WIDTH = 16
) (
  input  logic                           clk,
  input  pdad_pkg::op_t                  op,
  input  logic                           load,
  input  logic [pdad_pkg::DateW-1:0]     date_in,
  input  logic [pdad_pkg::CountInW-1:0]  day_count,
  output pdad_pkg::dp_stat_t             stat,
  output logic [pdad_pkg::DateW-1:0]     result
);
  import pdad_pkg::*;

  localparam int NW      = (DAYS_WIDTH + 1 > DateW) ? DAYS_WIDTH + 1 : DateW;
  localparam int CntUsed = (DAYS_WIDTH < CountInW) ? DAYS_WIDTH : CountInW;
  // floor(x / 1461) for x < 2^DAYS_WIDTH; reciprocal error below 2^11 keeps it exact
  localparam int MW      = DAYS_WIDTH + 1;
  localparam int SpanSh  = DAYS_WIDTH + 11;
  localparam int ProdSW  = SpanSh + SpanQW;
  localparam logic [63:0]   SpanOne   = 64'd1 << SpanSh;
  localparam logic [MW-1:0] RecipSpan = MW'((SpanOne + 64'(SpanDays - 1)) / 64'(SpanDays));

  logic [DateW-1:0]      date_keep;
  logic [DAYS_WIDTH-1:0] count;
  logic [RemW-1:0]       yfull;
  logic [RemW-1:0]       rem;
  logic [7:0]            quo;
  logic [NW-1:0]         day;
  logic [3:0]            mm;
  logic [6:0]            yy;
  logic [SpanQW-1:0]     k;
  logic [KqW-1:0]        kq;
  logic [DateW-1:0]      acc;

  logic [46:0]           prod_y;
  logic [24:0]           prod_m;
  logic [6:0]            dd;
  logic [DAYS_WIDTH-1:0] span_x;
  logic [ProdSW-1:0]     prod_s;
  logic [44:0]           prod_k;
  logic [4:0]            r25;
  logic [4:0]            mlen;
  logic [7:0]            yy_sum;
  logic [6:0]            yy_wrap;
  logic [DateW-1:0]      pack_lo;

  // constant divisions by reciprocal multiplication
  always_comb begin
    prod_y = 47'(date_keep[DateW-1:4]) * 47'(RecipYear);
    prod_m = 25'(rem[RemW-1:2]) * 25'(RecipMonth);
    dd     = 7'(rem - RemW'(quo) * RemW'(DivMonth));
    span_x = DAYS_WIDTH'(day - NW'(DayMax + 1));
    prod_s = ProdSW'(span_x) * ProdSW'(RecipSpan);
    prod_k = 45'(k) * 45'(Recip25);
    // span count mod 25, times four, gives the year offset of the four-year skip
    r25    = 5'(k - SpanQW'(kq) * SpanQW'(SpansPerCent));
  end

  always_comb begin
    mlen    = month_days(mm, yy[1:0] == 2'd0);
    yy_sum  = {1'b0, yy} + {1'b0, r25, 2'b00};
    yy_wrap = (yy_sum >= 8'd100) ? 7'(yy_sum - 8'd100) : yy_sum[6:0];
    pack_lo = acc + DateW'(mm) * DateW'(DivMonth) + DateW'(day[4:0]);
    result  = (op == OP_REJECT) ? date_keep : pack_lo;

    stat.bad        = (yfull < RemW'(YearBase)) || (yfull > RemW'(YearLast)) ||
                      (quo == '0) || (quo > 8'(MonthMax)) || (dd > 7'(DayMax));
    stat.short_span = day < NW'(SpanDays + DayMax + 1);
    stat.over       = day > NW'(mlen);
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_IDLE: begin
        if (load) begin
          date_keep <= date_in;
          count     <= DAYS_WIDTH'(day_count[CntUsed-1:0]);
        end
      end
      OP_DIV_Y: begin
        yfull <= prod_y[RecipYearSh +: RemW];
      end
      OP_SPLIT: begin
        rem <= RemW'(date_keep - DateW'(yfull) * DateW'(DivYear));
      end
      OP_DIV_M: begin
        quo <= prod_m[RecipMonthSh +: 8];
      end
      OP_CHECK: begin
        mm  <= quo[3:0];
        yy  <= 7'(yfull - RemW'(YearBase));
        day <= NW'(dd) + NW'(count);
      end
      OP_SKIP_SET: begin
        k <= prod_s[SpanSh +: SpanQW];
      end
      OP_SKIP_MOD: begin
        kq  <= prod_k[Recip25Sh +: KqW];
        day <= day - NW'(k) * NW'(SpanDays);
      end
      OP_SKIP_END: begin
        yy <= yy_wrap;
      end
      OP_WALK: begin
        if (stat.over) begin
          day <= day - NW'(mlen);
          if (mm == 4'(MonthMax)) begin
            mm <= 4'd1;
            yy <= (yy == 7'd99) ? 7'd0 : yy + 7'd1;
          end else begin
            mm <= mm + 4'd1;
          end
        end
      end
      OP_PACK_HI: begin
        acc <= (DateW'(yy) + DateW'(YearBase)) * DateW'(DivYear);
      end
      default: ;
    endcase
  end

endmodule

// File: src/packed_date_add_days.sv
// Adds a day count to a date given as the decimal number YYYYMMDD (2000..2099).
// Input: s_tvalid/s_tready/s_tdata, one transfer per date. Output:
// m_tvalid/m_tready/m_tdata with the new date and m_tuser = 1 when the
// date was in range and advanced, 0 when it came back unchanged.
// A short microprogram drives one datapath: the date is split by reciprocal
// multiplications, each in its own microstep, then one month is walked per cycle.
// From input transfer to result in the output register the sequencer steps
// through the year division, the split, the month division and the range
// check; an accepted date then skips whole four-year spans at once when
// day + count >= 1493, walks the months (at most 49) and runs the two pack
// steps, while a rejected date goes to the reject step. One date is worked
// at a time; s_tready is high only between dates, so the next date can be
// taken in the cycle after a result is loaded. The output register lets a
// new date be taken while the last result waits; if m_tready is still low
// when the next result is ready, the sequencer holds on its final step.
// Reset returns the sequencer to idle and empties the output register.
module packed_date_add_days #(
  parameter int DAYS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [26:0] date_in, [42:27] day_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [26:0] date_out
  output logic        m_tuser    // [0] accepted
);
  import pdad_pkg::*;

  pc_t        pc;
  pc_t        pc_next;
  uword_t     uw;
  dp_stat_t   stat;
  logic       take;
  logic       in_xfer;
  logic       out_busy;
  logic       out_wr;
  logic [DateW-1:0] result;
  logic [DateW-1:0] date_out;
  logic       accepted;

  assign uw       = ucode(pc);
  assign s_tready = uw.op == OP_IDLE;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;
  assign out_wr   = (uw.op == OP_PACK_LO || uw.op == OP_REJECT) && !out_busy;

  pdad_dp #(
    .DAYS_WIDTH(DAYS_WIDTH)
  ) u_dp (
    .clk       (clk),
    .op        (uw.op),
    .load      (in_xfer),
    .date_in   (s_tdata[DateW-1:0]),
    .day_count (s_tdata[DateW+CountInW-1:DateW]),
    .stat      (stat),
    .result    (result)
  );

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_NO_IN:    take = !in_xfer;
      C_BAD:      take = stat.bad;
      C_SHORT:    take = stat.short_span;
      C_OVER:     take = stat.over;
      C_OUT_BUSY: take = out_busy;
      default:    take = 1'b0;
    endcase
    pc_next = take ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      date_out <= result;
      accepted <= uw.op == OP_PACK_LO;
    end
  end

  assign m_tdata = {{(32 - DateW){1'b0}}, date_out};
  assign m_tuser = accepted;

  a_result_from_final_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(uw.op == OP_PACK_LO || uw.op == OP_REJECT))
    else $error("result appeared without a final microstep");

  a_final_step_delivers: assert property (@(posedge clk) disable iff (rst)
    out_wr |=> m_tvalid && pc == PC_IDLE)
    else $error("final microstep did not load output and return to idle");

  a_accept_starts_split: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> pc == PC_DIV_Y && !s_tready)
    else $error("input transfer did not start the date split");

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_LAST)
    else $error("step counter outside microprogram");

endmodule
